// File: hdl/rfct_pkg.sv
// Shared constants, action codes and node-memory types for the range flip / count tree.
// No dependencies.
package rfct_pkg;

    localparam int MAX_POSITIONS = 1024;
    localparam int POS_W         = 10;
    localparam int SIZE_W        = 11;
    localparam int CNT_W         = 11;
    localparam int NODE_DEPTH    = 2 * MAX_POSITIONS;
    localparam int NODE_W        = 11;
    localparam int STACK_DEPTH   = 11;
    localparam int SP_W          = 4;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_FLIP  = 2'd1,
        ACT_ONES  = 2'd2,
        ACT_ZEROS = 2'd3
    } action_t;

    typedef struct packed {
        logic             mark;
        logic [CNT_W-1:0] cnt;
    } node_word_t;

    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] addr;
        node_word_t        data;
    } node_wr_t;

endpackage

// File: hdl/rfct_req_if.sv
// Request and response channel interfaces.
// Depends on rfct_pkg.
interface rfct_req_if
    import rfct_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [1:0]       action;
    logic [POS_W-1:0] range_low;
    logic [POS_W-1:0] range_high;
    logic             bit_value;

    modport source (output valid, action, range_low, range_high, bit_value, input ready);
    modport sink   (input valid, action, range_low, range_high, bit_value, output ready);
endinterface

interface rfct_rsp_if
    import rfct_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] count;
    logic             range_error;

    modport source (output valid, count, range_error, input ready);
    modport sink   (input valid, count, range_error, output ready);
endinterface

// File: hdl/rfct_node_ram.sv
// Node memory: one write port, one read port with registered read data.
// Depends on rfct_pkg.
module rfct_node_ram
    import rfct_pkg::*;
(
    input  logic              clk,
    input  node_wr_t          wr,
    input  logic [NODE_W-1:0] rd_addr,
    output node_word_t        rd_data
);

    node_word_t mem [0:NODE_DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: hdl/range_flip_count_ones_tree_unit.sv
// Top level of the range flip / count segment tree with lazy flip marks.
// Depends on rfct_pkg, rfct_req_if, rfct_rsp_if and rfct_node_ram.
// Usage:
//   req carries one request (action, range_low, range_high, bit_value), taken
//   when req.valid and req.ready are high at a clock edge. rsp returns exactly
//   one result (count, range_error) per request, held until rsp.ready.
//   cfg_we with cfg_wdata sets size_in_use (0 taken as 1, above 1024 taken as
//   1024) and clears the tree; write it only while the block is idle.
// Operation:
//   One request at a time. A sequencer walks the tree with an explicit frame
//   stack through a node memory with registered reads. A node whose span lies
//   in the range is updated or summed; a split node first pushes its flip mark
//   down to both children, if it has one, then descends; after a load or flip
//   each node on the path is recombined from its children on the way back up.
//   An invalid range is answered without walking the tree.
// Reset and clear:
//   After reset and after each size write, a clearing pass zeroes the whole
//   node memory with req.ready low; a size write during it restarts it.
// Stall:
//   A finished result waits in the output register; the next request is
//   accepted meanwhile, and its result waits until the first one is taken.
module range_flip_count_ones_tree_unit
    import rfct_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    rfct_req_if.sink          req,
    rfct_rsp_if.source        rsp,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata
);

    typedef enum logic [13:0] {
        S_CLEAR = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_VISIT = 14'b00000000000100,
        S_NODE  = 14'b00000000001000,
        S_PL    = 14'b00000000010000,
        S_PR    = 14'b00000000100000,
        S_PC    = 14'b00000001000000,
        S_DESC  = 14'b00000010000000,
        S_RET   = 14'b00000100000000,
        S_UP    = 14'b00001000000000,
        S_CMB0  = 14'b00010000000000,
        S_CMB1  = 14'b00100000000000,
        S_CMB2  = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } state_t;

    typedef struct packed {
        logic [NODE_W-1:0] t;
        logic [POS_W-1:0]  l;
        logic [POS_W-1:0]  r;
        logic              ph;
    } frame_t;

    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [NODE_W-1:0] clr_reg, clr_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic              ovalid_reg, ovalid_next;

    action_t           act_reg, act_next;
    logic [POS_W-1:0]  ql_reg, ql_next;
    logic [POS_W-1:0]  qr_reg, qr_next;
    logic              bit_reg, bit_next;
    logic              err_reg, err_next;
    logic [CNT_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  tcnt_reg, tcnt_next;
    logic [CNT_W-1:0]  lcnt_reg, lcnt_next;
    frame_t            cur_reg, cur_next;
    logic              ph_reg, ph_next;
    logic [CNT_W-1:0]  ocnt_reg, ocnt_next;
    logic              oerr_reg, oerr_next;

    frame_t            stack_reg [0:STACK_DEPTH-1];
    logic              push;
    frame_t            push_frame;

    node_wr_t          wr;
    logic [NODE_W-1:0] rd_addr;
    node_word_t        rd_data;

    logic [SIZE_W-1:0] v_clamped;
    logic [SIZE_W-1:0] sum_lr;
    logic [POS_W-1:0]  mid;
    logic [CNT_W-1:0]  span, lspan, rspan;
    logic [NODE_W-1:0] lc, rc;
    logic              covered;
    logic              go_left;
    logic              need_right;
    logic              in_err;
    logic [CNT_W-1:0]  result_cnt;

    rfct_node_ram u_ram (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        sum_lr = {1'b0, cur_reg.l} + {1'b0, cur_reg.r};
        mid    = sum_lr[SIZE_W-1:1];
        span   = {1'b0, cur_reg.r} - {1'b0, cur_reg.l} + CNT_W'(1);
        lspan  = {1'b0, mid} - {1'b0, cur_reg.l} + CNT_W'(1);
        rspan  = {1'b0, cur_reg.r} - {1'b0, mid};
        lc     = cur_reg.t + NODE_W'(1);
        rc     = cur_reg.t + NODE_W'({lspan, 1'b0});
        if (act_reg == ACT_LOAD)
        begin
            covered = (cur_reg.l == cur_reg.r);
            go_left = (ql_reg <= mid);
        end
        else
        begin
            covered = (ql_reg <= cur_reg.l) && (cur_reg.r <= qr_reg);
            go_left = (ql_reg <= mid);
        end
        need_right = (act_reg != ACT_LOAD) && (mid < qr_reg);

        if (cfg_wdata == '0)
        begin
            v_clamped = SIZE_W'(1);
        end
        else if (cfg_wdata > SIZE_W'(MAX_POSITIONS))
        begin
            v_clamped = SIZE_W'(MAX_POSITIONS);
        end
        else
        begin
            v_clamped = cfg_wdata;
        end

        if (action_t'(req.action) == ACT_LOAD)
        begin
            in_err = ({1'b0, req.range_low} >= size_reg);
        end
        else
        begin
            in_err = (req.range_low > req.range_high) || ({1'b0, req.range_high} >= size_reg);
        end

        if (err_reg || act_reg == ACT_LOAD || act_reg == ACT_FLIP)
        begin
            result_cnt = '0;
        end
        else if (act_reg == ACT_ONES)
        begin
            result_cnt = sum_reg;
        end
        else
        begin
            result_cnt = ({1'b0, qr_reg} - {1'b0, ql_reg} + CNT_W'(1)) - sum_reg;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        size_next   = size_reg;
        clr_next    = clr_reg;
        sp_next     = sp_reg;
        ovalid_next = ovalid_reg;
        act_next    = act_reg;
        ql_next     = ql_reg;
        qr_next     = qr_reg;
        bit_next    = bit_reg;
        err_next    = err_reg;
        sum_next    = sum_reg;
        tcnt_next   = tcnt_reg;
        lcnt_next   = lcnt_reg;
        cur_next    = cur_reg;
        ph_next     = ph_reg;
        ocnt_next   = ocnt_reg;
        oerr_next   = oerr_reg;
        push        = 1'b0;
        push_frame  = cur_reg;
        wr          = '0;
        rd_addr     = cur_reg.t;

        if (rsp.valid && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                wr.we    = 1'b1;
                wr.addr  = clr_reg;
                clr_next = clr_reg + NODE_W'(1);
                if (cfg_we)
                begin
                    size_next = v_clamped;
                    clr_next  = '0;
                end
                else if (clr_reg == NODE_W'(NODE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    size_next  = v_clamped;
                    clr_next   = '0;
                    state_next = S_CLEAR;
                end
                else if (req.valid)
                begin
                    act_next   = action_t'(req.action);
                    ql_next    = req.range_low;
                    qr_next    = req.range_high;
                    bit_next   = req.bit_value;
                    err_next   = in_err;
                    sum_next   = '0;
                    sp_next    = '0;
                    cur_next.t = '0;
                    cur_next.l = '0;
                    cur_next.r = POS_W'(size_reg - SIZE_W'(1));
                    state_next = in_err ? S_DONE : S_VISIT;
                end
            end
            S_VISIT:
            begin
                state_next = S_NODE;
            end
            S_NODE:
            begin
                tcnt_next = rd_data.cnt;
                if (covered)
                begin
                    wr.addr = cur_reg.t;
                    case (act_reg)
                        ACT_LOAD:
                        begin
                            wr.we   = 1'b1;
                            wr.data = '{mark: 1'b0, cnt: CNT_W'(bit_reg)};
                        end
                        ACT_FLIP:
                        begin
                            wr.we   = 1'b1;
                            wr.data = '{mark: ~rd_data.mark, cnt: span - rd_data.cnt};
                        end
                        default:
                        begin
                            sum_next = sum_reg + rd_data.cnt;
                        end
                    endcase
                    state_next = S_RET;
                end
                else if (rd_data.mark)
                begin
                    rd_addr    = lc;
                    state_next = S_PL;
                end
                else
                begin
                    state_next = S_DESC;
                end
            end
            S_PL:
            begin
                wr.we      = 1'b1;
                wr.addr    = lc;
                wr.data    = '{mark: ~rd_data.mark, cnt: lspan - rd_data.cnt};
                rd_addr    = rc;
                state_next = S_PR;
            end
            S_PR:
            begin
                wr.we      = 1'b1;
                wr.addr    = rc;
                wr.data    = '{mark: ~rd_data.mark, cnt: rspan - rd_data.cnt};
                state_next = S_PC;
            end
            S_PC:
            begin
                wr.we      = 1'b1;
                wr.addr    = cur_reg.t;
                wr.data    = '{mark: 1'b0, cnt: tcnt_reg};
                state_next = S_DESC;
            end
            S_DESC:
            begin
                push    = 1'b1;
                sp_next = sp_reg + SP_W'(1);
                if (go_left)
                begin
                    push_frame.ph = 1'b0;
                    cur_next.t    = lc;
                    cur_next.r    = mid;
                end
                else
                begin
                    push_frame.ph = 1'b1;
                    cur_next.t    = rc;
                    cur_next.l    = mid + POS_W'(1);
                end
                state_next = S_VISIT;
            end
            S_RET:
            begin
                if (sp_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cur_next   = stack_reg[sp_reg - SP_W'(1)];
                    ph_next    = stack_reg[sp_reg - SP_W'(1)].ph;
                    sp_next    = sp_reg - SP_W'(1);
                    state_next = S_UP;
                end
            end
            S_UP:
            begin
                if (!ph_reg && need_right)
                begin
                    push          = 1'b1;
                    push_frame.ph = 1'b1;
                    sp_next       = sp_reg + SP_W'(1);
                    cur_next.t    = rc;
                    cur_next.l    = mid + POS_W'(1);
                    state_next    = S_VISIT;
                end
                else if (act_reg == ACT_ONES || act_reg == ACT_ZEROS)
                begin
                    state_next = S_RET;
                end
                else
                begin
                    state_next = S_CMB0;
                end
            end
            S_CMB0:
            begin
                rd_addr    = lc;
                state_next = S_CMB1;
            end
            S_CMB1:
            begin
                lcnt_next  = rd_data.cnt;
                rd_addr    = rc;
                state_next = S_CMB2;
            end
            S_CMB2:
            begin
                wr.we      = 1'b1;
                wr.addr    = cur_reg.t;
                wr.data    = '{mark: 1'b0, cnt: lcnt_reg + rd_data.cnt};
                state_next = S_RET;
            end
            S_DONE:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    ocnt_next   = result_cnt;
                    oerr_next   = err_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            size_reg   <= SIZE_W'(MAX_POSITIONS);
            clr_reg    <= '0;
            sp_reg     <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            size_reg   <= size_next;
            clr_reg    <= clr_next;
            sp_reg     <= sp_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        ql_reg   <= ql_next;
        qr_reg   <= qr_next;
        bit_reg  <= bit_next;
        err_reg  <= err_next;
        sum_reg  <= sum_next;
        tcnt_reg <= tcnt_next;
        lcnt_reg <= lcnt_next;
        cur_reg  <= cur_next;
        ph_reg   <= ph_next;
        ocnt_reg <= ocnt_next;
        oerr_reg <= oerr_next;
        if (push)
        begin
            stack_reg[sp_reg] <= push_frame;
        end
    end

    assign req.ready       = (state_reg == S_IDLE) && !cfg_we;
    assign rsp.valid       = ovalid_reg;
    assign rsp.count       = ocnt_reg;
    assign rsp.range_error = oerr_reg;

`ifndef ASSERT_OFF
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("frame stack overflow");

    a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !req.ready)
        else $error("request taken during clear");

    a_err_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.range_error) |-> (rsp.count == '0))
        else $error("nonzero count on error");

    a_done_empty_stack: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (sp_reg == '0))
        else $error("result with frames left");
`endif

endmodule
